// ----- src/serial_line_ring_with_ack_top_assert.svh -----
// Assertion macros for the serial line ring.
// Used by serial_line_ring_with_ack_top; expects aclk and aresetn in scope.
`ifndef SERIAL_LINE_RING_WITH_ACK_TOP_ASSERT_SVH
`define SERIAL_LINE_RING_WITH_ACK_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SLRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SLRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/slra_pkg.sv -----
// Shared constants and helpers for the serial line ring.
// No dependencies; imported by serial_line_ring_with_ack_top.
package slra_pkg;

    // Ring geometry
    localparam int LINE_SLOTS = 64;
    localparam int LINE_LEN   = 128;
    localparam int SLOT_W     = $clog2(LINE_SLOTS);
    localparam int LEN_W      = $clog2(LINE_LEN);
    localparam int CNT_W      = 6;

    // Character codes
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Action codes
    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_FLUSH  = 3'd1;
    localparam logic [2:0] ACT_STATUS = 3'd2;
    localparam logic [2:0] ACT_ACK    = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LEN_W-1:0]  len_t;

    // Ring successor with wrap
    function automatic slot_t next_slot(input slot_t s);
        return (s == SLOT_W'(LINE_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// ----- src/serial_line_ring_with_ack_top.sv -----
// Serial line ring with acknowledge: assembly buffer, line store and length memories.
// Depends on slra_pkg and serial_line_ring_with_ack_top_assert.svh.
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | tdata: rx_byte, acked_seq; tuser: action
//  result  | m_tvalid m_tready m_tdata m_tuser | tdata: out_byte, last_seq, line_count,
//          |                                |        dropped_count; tuser: stream_end
//
// Push and flush pass through the execute state only. Status and ack then go to the
// response state; a read adds a data state before it, except at the stream end, as the
// length and byte memories have registered reads. A push that completes a line copies
// it from the assembly buffer into the line store, one byte a cycle, in the copy state.
// A new transfer is taken while a result still waits in the output register; a stalled
// result holds the block only once the next result is ready. No clearing pass after reset.
module serial_line_ring_with_ack_top
    import slra_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] acked_seq
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] out_byte, [39:8] last_seq, [45:40] line_count,
                                   // [77:46] dropped_count, [79:78] zero
    output logic [0:0]  m_tuser    // [0] stream_end
);

    `include "serial_line_ring_with_ack_top_assert.svh"

    localparam int STORE_W = SLOT_W + LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_RDATA,
        S_RESP
    } state_t;

    // Control and payload registers
    state_t      state_reg, state_next;
    logic [2:0]  act_reg, act_next;
    logic [7:0]  byte_reg, byte_next;
    logic [31:0] acked_reg, acked_next;
    len_t        asm_len_reg, asm_len_next;
    slot_t       head_reg, head_next;
    slot_t       tail_reg, tail_next;
    logic [31:0] pushed_reg, pushed_next;
    logic [31:0] dropped_reg, dropped_next;
    slot_t       cur_line_reg, cur_line_next;
    len_t        cur_off_reg, cur_off_next;
    slot_t       cur_stop_reg, cur_stop_next;
    len_t        cp_idx_reg, cp_idx_next;
    len_t        cp_widx_reg, cp_widx_next;
    logic        cp_wv_reg, cp_wv_next;
    logic        pend_reg, pend_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        oend_reg, oend_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [79:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    // Memories
    logic [7:0] asm_mem   [LINE_LEN];
    logic [7:0] store_mem [LINE_SLOTS * (2 ** LEN_W)];
    len_t       len_mem   [LINE_SLOTS];

    logic       asm_we;
    len_t       asm_waddr;
    logic [7:0] asm_wdata;
    logic [7:0] asm_q;
    logic       store_we;
    logic [7:0] store_q;
    logic       len_we;
    len_t       len_q;

    // Ack arithmetic
    slot_t              held;
    logic [31:0]        ack_diff, ack_first, ack_rel;
    slot_t              ack_drop;
    logic [SLOT_W:0]    ack_sum;
    slot_t              ack_tail;

    logic s_xfer;
    logic out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Lines held in the ring
    always_comb begin
        if (head_reg >= tail_reg) begin
            held = head_reg - tail_reg;
        end else begin
            held = SLOT_W'((SLOT_W + 1)'(LINE_SLOTS) - {1'b0, tail_reg} + {1'b0, head_reg});
        end
    end

    // Release window: serial-number compare against the oldest and newest held lines
    always_comb begin
        ack_diff  = acked_reg - pushed_reg;
        ack_rel   = ack_diff + 32'(held);
        ack_first = ack_rel - 32'd1;
        ack_drop  = ack_diff[31] ? ack_rel[SLOT_W-1:0] : held;
        ack_sum   = {1'b0, tail_reg} + {1'b0, ack_drop};
        if (ack_sum >= (SLOT_W + 1)'(LINE_SLOTS)) begin
            ack_tail = SLOT_W'(ack_sum - (SLOT_W + 1)'(LINE_SLOTS));
        end else begin
            ack_tail = ack_sum[SLOT_W-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        byte_next     = byte_reg;
        acked_next    = acked_reg;
        asm_len_next  = asm_len_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        pushed_next   = pushed_reg;
        dropped_next  = dropped_reg;
        cur_line_next = cur_line_reg;
        cur_off_next  = cur_off_reg;
        cur_stop_next = cur_stop_reg;
        cp_idx_next   = cp_idx_reg;
        cp_widx_next  = cp_widx_reg;
        cp_wv_next    = 1'b0;
        pend_next     = pend_reg;
        obyte_next    = obyte_reg;
        oend_next     = oend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        asm_we        = 1'b0;
        asm_waddr     = asm_len_reg;
        asm_wdata     = byte_reg;
        len_we        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    act_next   = s_tuser;
                    byte_next  = s_tdata[7:0];
                    acked_next = s_tdata[39:8];
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                obyte_next = '0;
                oend_next  = 1'b0;
                state_next = S_IDLE;
                case (act_reg)
                    ACT_PUSH: begin
                        if (byte_reg == CH_CR) begin
                            state_next = S_IDLE;
                        end else if (byte_reg == CH_LF || asm_len_reg == LEN_W'(LINE_LEN - 1)) begin
                            pend_next = (byte_reg != CH_LF);
                            if (asm_len_reg != '0) begin
                                // store the line, dropping the oldest when full
                                if (next_slot(head_reg) == tail_reg) begin
                                    tail_next    = next_slot(tail_reg);
                                    dropped_next = dropped_reg + 32'd1;
                                end
                                cp_idx_next = '0;
                                state_next  = S_COPY;
                            end
                        end else begin
                            asm_we       = 1'b1;
                            asm_len_next = asm_len_reg + 1'b1;
                        end
                    end
                    ACT_FLUSH: begin
                        tail_next    = head_reg;
                        asm_len_next = '0;
                        dropped_next = '0;
                    end
                    ACT_STATUS: begin
                        state_next = S_RESP;
                    end
                    ACT_ACK: begin
                        if (held != '0 && !ack_first[31]) begin
                            tail_next     = ack_tail;
                            cur_line_next = ack_tail;
                        end else begin
                            cur_line_next = tail_reg;
                        end
                        cur_stop_next = head_reg;
                        cur_off_next  = '0;
                        state_next    = S_RESP;
                    end
                    ACT_READ: begin
                        if (cur_line_reg == cur_stop_reg) begin
                            oend_next  = 1'b1;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_RDATA;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Assembly buffer to line store, one byte a cycle
            S_COPY: begin
                if (cp_idx_reg != asm_len_reg) begin
                    cp_widx_next = cp_idx_reg;
                    cp_wv_next   = 1'b1;
                    cp_idx_next  = cp_idx_reg + 1'b1;
                end else begin
                    len_we      = 1'b1;
                    head_next   = next_slot(head_reg);
                    pushed_next = pushed_reg + 32'd1;
                    if (pend_reg) begin
                        asm_we       = 1'b1;
                        asm_waddr    = '0;
                        asm_len_next = LEN_W'(1);
                    end else begin
                        asm_len_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            // Length and byte of the cursor position are now valid
            S_RDATA: begin
                if (cur_off_reg < len_q) begin
                    obyte_next   = store_q;
                    cur_off_next = cur_off_reg + 1'b1;
                end else begin
                    obyte_next    = CH_LF;
                    cur_off_next  = '0;
                    cur_line_next = next_slot(cur_line_reg);
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, dropped_reg, CNT_W'(held), pushed_reg, obyte_reg};
                    m_tuser_next  = oend_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            asm_len_reg  <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            pushed_reg   <= '0;
            dropped_reg  <= '0;
            cur_line_reg <= '0;
            cur_off_reg  <= '0;
            cur_stop_reg <= '0;
            cp_wv_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            asm_len_reg  <= asm_len_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            pushed_reg   <= pushed_next;
            dropped_reg  <= dropped_next;
            cur_line_reg <= cur_line_next;
            cur_off_reg  <= cur_off_next;
            cur_stop_reg <= cur_stop_next;
            cp_wv_reg    <= cp_wv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        act_reg     <= act_next;
        byte_reg    <= byte_next;
        acked_reg   <= acked_next;
        cp_idx_reg  <= cp_idx_next;
        cp_widx_reg <= cp_widx_next;
        pend_reg    <= pend_next;
        obyte_reg   <= obyte_next;
        oend_reg    <= oend_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Assembly buffer: written by pushes, read by the copy
    always_ff @(posedge aclk) begin
        if (asm_we) begin
            asm_mem[asm_waddr] <= asm_wdata;
        end
        asm_q <= asm_mem[cp_idx_reg];
    end

    // Line store: written by the copy at the head slot, read at the cursor
    assign store_we = (state_reg == S_COPY) && cp_wv_reg;

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[{head_reg, cp_widx_reg}] <= asm_q;
        end
        store_q <= store_mem[STORE_W'({cur_line_reg, cur_off_reg})];
    end

    // Line lengths
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[head_reg] <= asm_len_reg;
        end
        len_q <= len_mem[cur_line_reg];
    end

    // Checks
    `SLRA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready,
        "input taken while a transfer is still in work")
    `SLRA_ASSERT_NOW(a_copy_nonempty, state_reg == S_COPY, asm_len_reg != '0,
        "line copy started with an empty line")
    `SLRA_ASSERT_NOW(a_end_no_byte, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h00,
        "stream end result carries a byte")
    `SLRA_ASSERT_NEXT(a_flush_empties, state_reg == S_EXEC && act_reg == ACT_FLUSH,
        head_reg == tail_reg && asm_len_reg == '0, "flush left lines in the ring")

endmodule
